### rtl/hsvc_pkg.sv
package hsvc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DEN_BITS       = 16;
    localparam int HUE_BITS       = 9;
    localparam int RGB_BITS       = 24;
    localparam int IN_BITS        = 16;
    localparam int ADDR_BITS      = 4;
    localparam int DATA_BITS      = 32;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_HUE  = 2'd1;
    localparam logic [1:0] MODE_SAT  = 2'd2;
    localparam logic [1:0] MODE_VAL  = 2'd3;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_DIV  = 2'd1;
    localparam logic [1:0] REG_HUE  = 2'd2;
    localparam logic [1:0] REG_MAX  = 2'd3;

    localparam logic [HUE_BITS-1:0] HUE_WRAP = 9'd360;

    typedef struct packed {
        logic                black;
        logic [1:0]          mode;
        logic                ramp_zero;
        logic                ramp_one;
        logic [HUE_BITS-1:0] fhue;
    } t_meta;

    typedef struct packed {
        logic [1:0]          color_mode;
        logic [DEN_BITS-1:0] hue_divisor;
        logic [HUE_BITS-1:0] fixed_hue;
        logic [DEN_BITS-1:0] max_iterations;
    } t_cfg;

endpackage

### rtl/hsvc_pix_if.sv
interface hsvc_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] iter_count;

    modport source (output valid, output iter_count, input ready);
    modport sink   (input valid, input iter_count, output ready);
endinterface

### rtl/hsvc_rgb_if.sv
interface hsvc_rgb_if;
    logic        valid;
    logic        ready;
    logic [23:0] rgb_color;

    modport source (output valid, output rgb_color, input ready);
    modport sink   (input valid, input rgb_color, output ready);
endinterface

### rtl/hsvc_cfg.sv
module hsvc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsvc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [hsvc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [hsvc_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    output hsvc_pkg::t_cfg                   o_cfg
);
    hsvc_pkg::t_cfg r_cfg;
    logic [1:0]     idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode     <= hsvc_pkg::MODE_HUE;
            r_cfg.hue_divisor    <= 16'd1;
            r_cfg.fixed_hue      <= 9'd0;
            r_cfg.max_iterations <= 16'd50;
        end else if (psel && penable && pwrite) begin
            case (idx)
                hsvc_pkg::REG_MODE: r_cfg.color_mode     <= pwdata[1:0];
                hsvc_pkg::REG_DIV:  r_cfg.hue_divisor    <= pwdata[15:0];
                hsvc_pkg::REG_HUE:  r_cfg.fixed_hue      <= pwdata[8:0];
                hsvc_pkg::REG_MAX:  r_cfg.max_iterations <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            hsvc_pkg::REG_MODE: prdata = 32'(r_cfg.color_mode);
            hsvc_pkg::REG_DIV:  prdata = 32'(r_cfg.hue_divisor);
            hsvc_pkg::REG_HUE:  prdata = 32'(r_cfg.fixed_hue);
            hsvc_pkg::REG_MAX:  prdata = 32'(r_cfg.max_iterations);
            default:            prdata = '0;
        endcase
    end
endmodule

### rtl/hsvc_div.sv
// Restoring divider, one quotient bit per stage.
module hsvc_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  hsvc_pkg::t_meta i_meta,
    output logic           o_valid,
    output logic [NW-1:0]  o_quo,
    output hsvc_pkg::t_meta o_meta
);
    logic            r_valid [NW];
    logic [NW-1:0]   r_num   [NW];
    logic [NW-1:0]   r_quo   [NW];
    logic [DW-1:0]   r_rem   [NW];
    logic [DW-1:0]   r_den   [NW];
    hsvc_pkg::t_meta r_meta  [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic            v_in;
        logic [NW-1:0]   num_in, quo_in;
        logic [DW-1:0]   rem_in, den_in;
        hsvc_pkg::t_meta meta_in;
        logic [DW:0]     t;
        logic            ge;
        logic [DW-1:0]   n_rem;

        if (i == 0) begin : g_first
            assign v_in    = i_valid;
            assign num_in  = i_num;
            assign quo_in  = '0;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign meta_in = i_meta;
        end else begin : g_next
            assign v_in    = r_valid[i-1];
            assign num_in  = r_num[i-1];
            assign quo_in  = r_quo[i-1];
            assign rem_in  = r_rem[i-1];
            assign den_in  = r_den[i-1];
            assign meta_in = r_meta[i-1];
        end

        assign t     = {rem_in, num_in[NW-1]};
        assign ge    = t >= {1'b0, den_in};
        assign n_rem = ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[i]  <= {num_in[NW-2:0], 1'b0};
                r_quo[i]  <= {quo_in[NW-2:0], ge};
                r_rem[i]  <= n_rem;
                r_den[i]  <= den_in;
                r_meta[i] <= meta_in;
            end
        end
    end

    assign o_valid = r_valid[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_meta  = r_meta[NW-1];
endmodule

### rtl/hsvc_mod.sv
// Reduces the hue quotient modulo 360 in three register stages.
// x mod 360 = 8 * ((x >> 3) mod 45) + x[2:0]; since 4096 mod 45 = 1, the
// 12-bit chunks of x >> 3 are summed, folded to 12 bits, and the last
// step uses a reciprocal multiply by ceil(2^18 / 45).
// Items of every mode but the hue mode pass through untouched.
module hsvc_mod #(
    parameter int NW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_x,
    input  hsvc_pkg::t_meta i_meta,
    output logic            o_valid,
    output logic [NW-1:0]   o_x,
    output hsvc_pkg::t_meta o_meta
);
    localparam int YW = NW - 3;
    localparam int NC = (YW + 11) / 12;
    localparam int PW = NC * 12;
    localparam int SW = 16;
    localparam logic [24:0] RECIP45 = 25'd5826;

    logic [2:0]      r_valid;
    // stage 1
    logic [PW-1:0]   ypad;
    logic [SW-1:0]   n_sum, r_sum;
    logic [2:0]      r1_low;
    logic [NW-1:0]   r1_x;
    hsvc_pkg::t_meta r1_meta;
    // stage 2
    logic [12:0]     fold1;
    logic [11:0]     n_fold, r_fold;
    logic [2:0]      r2_low;
    logic [NW-1:0]   r2_x;
    hsvc_pkg::t_meta r2_meta;
    // stage 3
    logic [24:0]     qprod;
    logic [6:0]      q45;
    logic [5:0]      r45;
    logic [NW-1:0]   r3_x;
    hsvc_pkg::t_meta r3_meta;

    always_comb begin
        ypad  = PW'(i_x >> 3);
        n_sum = '0;
        for (int k = 0; k < NC; k++) begin
            n_sum = n_sum + SW'(ypad[k*12 +: 12]);
        end
    end

    assign fold1  = 13'(r_sum[11:0]) + 13'(r_sum[SW-1:12]);
    assign n_fold = fold1[12] ? 12'(fold1[11:0] + 12'd1) : fold1[11:0];

    assign qprod = 25'(r_fold) * RECIP45;
    assign q45   = qprod[24:18];
    assign r45   = 6'(r_fold - 12'(q45) * 12'd45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= n_sum;
            r1_low  <= i_x[2:0];
            r1_x    <= i_x;
            r1_meta <= i_meta;

            r_fold  <= n_fold;
            r2_low  <= r1_low;
            r2_x    <= r1_x;
            r2_meta <= r1_meta;

            r3_x    <= (r2_meta.mode == hsvc_pkg::MODE_HUE) ? NW'({r45, r2_low}) : r2_x;
            r3_meta <= r2_meta;
        end
    end

    assign o_valid = r_valid[2];
    assign o_x     = r3_x;
    assign o_meta  = r3_meta;
endmodule

### rtl/hsvc_hsv.sv
// Six-sector HSV to RGB, five register stages.
module hsvc_hsv #(
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [hsvc_pkg::HUE_BITS-1:0] i_hue,
    input  logic [F:0]                    i_s,
    input  logic [F:0]                    i_v,
    input  logic                          i_black,
    output logic                          o_valid,
    output logic [hsvc_pkg::RGB_BITS-1:0] o_rgb
);
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    // reciprocal of 60, exact for (rem << F) / 60 with rem < 60
    localparam longint unsigned RECIP = ((64'd1 << (F + 12)) + 64'd59) / 64'd60;
    localparam logic [F+6:0] RECIP_W = (F+7)'(RECIP);

    logic [4:0] r_valid;

    // stage 1
    logic [2:0] n_sec, r1_sec;
    logic [8:0] base;
    logic [5:0] r1_rem;
    logic [F:0] r1_s, r1_v;
    logic       r1_black;
    // stage 2
    logic [2:0] r2_sec;
    logic [F-1:0] r2_f;
    logic [F:0] r2_s, r2_v;
    logic       r2_black;
    logic [F+11:0] fprod;
    // stage 3
    logic [2:0] r3_sec;
    logic [F:0] r3_sf, r3_s1f, r3_s, r3_v;
    logic [7:0] r3_vv;
    logic       r3_black;
    logic [2*F+1:0] sf_prod, s1f_prod;
    logic [F+8:0]   vv_prod;
    // stage 4
    logic [2:0] r4_sec;
    logic [2*F+1:0] r4_ap, r4_aq, r4_at;
    logic [7:0] r4_vv;
    logic       r4_black;
    // stage 5
    logic [7:0] cp, cq, ct, n_r, n_g, n_b;
    logic [hsvc_pkg::RGB_BITS-1:0] r5_rgb;

    function automatic logic [7:0] chan255(input logic [2*F+1:0] a);
        logic [2*F+9:0] m;
        m = ({8'd0, a} << 8) - {8'd0, a};
        return m[2*F+7:2*F];
    endfunction

    always_comb begin
        if      (i_hue >= 9'd300) n_sec = 3'd5;
        else if (i_hue >= 9'd240) n_sec = 3'd4;
        else if (i_hue >= 9'd180) n_sec = 3'd3;
        else if (i_hue >= 9'd120) n_sec = 3'd2;
        else if (i_hue >= 9'd60)  n_sec = 3'd1;
        else                      n_sec = 3'd0;
        case (n_sec)
            3'd1:    base = 9'd60;
            3'd2:    base = 9'd120;
            3'd3:    base = 9'd180;
            3'd4:    base = 9'd240;
            3'd5:    base = 9'd300;
            default: base = 9'd0;
        endcase
    end

    assign fprod    = (F+12)'(r1_rem) * (F+12)'(RECIP_W);
    assign sf_prod  = (2*F+2)'(r2_s) * (2*F+2)'(r2_f);
    assign s1f_prod = (2*F+2)'(r2_s) * (2*F+2)'(ONE - {1'b0, r2_f});
    assign vv_prod  = ({8'd0, r2_v} << 8) - {8'd0, r2_v};

    assign cp = chan255(r4_ap);
    assign cq = chan255(r4_aq);
    assign ct = chan255(r4_at);

    always_comb begin
        case (r4_sec)
            3'd0:    begin n_r = r4_vv; n_g = ct;    n_b = cp;    end
            3'd1:    begin n_r = cq;    n_g = r4_vv; n_b = cp;    end
            3'd2:    begin n_r = cp;    n_g = r4_vv; n_b = ct;    end
            3'd3:    begin n_r = cp;    n_g = cq;    n_b = r4_vv; end
            3'd4:    begin n_r = ct;    n_g = cp;    n_b = r4_vv; end
            default: begin n_r = r4_vv; n_g = cp;    n_b = cq;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sec   <= n_sec;
            r1_rem   <= 6'(i_hue - base);
            r1_s     <= i_s;
            r1_v     <= i_v;
            r1_black <= i_black;

            r2_sec   <= r1_sec;
            r2_f     <= fprod[F+11:12];
            r2_s     <= r1_s;
            r2_v     <= r1_v;
            r2_black <= r1_black;

            r3_sec   <= r2_sec;
            r3_sf    <= sf_prod[2*F:F];
            r3_s1f   <= s1f_prod[2*F:F];
            r3_vv    <= vv_prod[F+7:F];
            r3_s     <= r2_s;
            r3_v     <= r2_v;
            r3_black <= r2_black;

            r4_sec   <= r3_sec;
            r4_ap    <= (2*F+2)'(r3_v) * (2*F+2)'(ONE - r3_s);
            r4_aq    <= (2*F+2)'(r3_v) * (2*F+2)'(ONE - r3_sf);
            r4_at    <= (2*F+2)'(r3_v) * (2*F+2)'(ONE - r3_s1f);
            r4_vv    <= r3_vv;
            r4_black <= r3_black;

            r5_rgb   <= r4_black ? '0 : {n_r, n_g, n_b};
        end
    end

    assign o_valid = r_valid[4];
    assign o_rgb   = r5_rgb;
endmodule

### rtl/iteration_count_hsv_colorizer.sv
// Iteration-count colorizer: one escape count in, one packed RGB pixel out.
// i_pix carries iter_count requests, o_rgb returns rgb_color (R 23:16,
// G 15:8, B 7:0); both are valid/ready channels, a request moves when
// valid and ready are high at a clock edge. The APB port holds color_mode,
// hue_divisor, fixed_hue and max_iterations at byte offsets 0, 4, 8, 12;
// write them only while no pixel is in flight.
// Throughput: one pixel per cycle while the receiver does not stall. The
// path from accept to result valid runs through one entry stage, the
// bit-per-stage divider (NW stages, NW = COUNT_BITS + max(FRAC_BITS, 9)),
// the mod-360 reduction (3 stages) and the five HSV stages.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults. When the receiver holds ready low with a result
// waiting, the whole pipeline freezes and i_pix.ready drops; nothing is
// lost or repeated.
module iteration_count_hsv_colorizer #(
    parameter int COUNT_BITS = hsvc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = hsvc_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hsvc_pix_if.sink                         i_pix,
    hsvc_rgb_if.source                       o_rgb,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsvc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [hsvc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [hsvc_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);
    localparam int NW = COUNT_BITS + ((FRAC_BITS > 9) ? FRAC_BITS : 9);
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int DW = hsvc_pkg::DEN_BITS;

    hsvc_pkg::t_cfg  cfg;
    logic            en;
    logic            out_valid;

    logic [COUNT_BITS-1:0] count;
    logic [CW-1:0]   cext, mext;
    hsvc_pkg::t_meta n_meta, r_meta;
    logic [NW-1:0]   n_num, r_num;
    logic [DW-1:0]   n_den, r_den;
    logic            r_valid;

    logic            div_valid;
    logic [NW-1:0]   div_quo;
    hsvc_pkg::t_meta div_meta;
    logic            mod_valid;
    logic [NW-1:0]   mod_x;
    hsvc_pkg::t_meta mod_meta;

    logic [hsvc_pkg::HUE_BITS-1:0] hue;
    logic [FRAC_BITS:0] ramp, sat, val;

    hsvc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign en          = !out_valid || o_rgb.ready;
    assign i_pix.ready = en;
    assign o_rgb.valid = out_valid;

    assign count = COUNT_BITS'(i_pix.iter_count);
    assign cext  = CW'(count);
    assign mext  = CW'(cfg.max_iterations);

    always_comb begin
        n_meta.black     = cext == mext;
        n_meta.mode      = cfg.color_mode;
        n_meta.ramp_zero = count <= COUNT_BITS'(2);
        n_meta.ramp_one  = cext >= mext;
        n_meta.fhue      = (cfg.fixed_hue >= hsvc_pkg::HUE_WRAP) ?
                           cfg.fixed_hue - hsvc_pkg::HUE_WRAP : cfg.fixed_hue;
        if (cfg.color_mode == hsvc_pkg::MODE_HUE) begin
            n_num = NW'(count) * NW'(hsvc_pkg::HUE_WRAP);
            n_den = (cfg.hue_divisor == '0) ? DW'(1) : cfg.hue_divisor;
        end else begin
            n_num = NW'(count - COUNT_BITS'(2)) << FRAC_BITS;
            n_den = cfg.max_iterations - DW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta <= n_meta;
            r_num  <= n_num;
            r_den  <= n_den;
        end
    end

    hsvc_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_valid),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_meta  (r_meta),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_meta  (div_meta)
    );

    hsvc_mod #(.NW(NW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_x     (div_quo),
        .i_meta  (div_meta),
        .o_valid (mod_valid),
        .o_x     (mod_x),
        .o_meta  (mod_meta)
    );

    always_comb begin
        if (mod_meta.ramp_zero)      ramp = '0;
        else if (mod_meta.ramp_one)  ramp = {1'b1, {FRAC_BITS{1'b0}}};
        else                         ramp = {1'b0, mod_x[FRAC_BITS-1:0]};
        sat = {1'b1, {FRAC_BITS{1'b0}}};
        val = {1'b1, {FRAC_BITS{1'b0}}};
        case (mod_meta.mode)
            hsvc_pkg::MODE_HUE: hue = mod_x[hsvc_pkg::HUE_BITS-1:0];
            hsvc_pkg::MODE_SAT: begin hue = mod_meta.fhue; sat = ramp; end
            hsvc_pkg::MODE_VAL: begin hue = mod_meta.fhue; val = ramp; end
            default:            hue = '0;
        endcase
    end

    hsvc_hsv #(.F(FRAC_BITS)) u_hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mod_valid),
        .i_hue   (hue),
        .i_s     (sat),
        .i_v     (val),
        .i_black (mod_meta.black),
        .o_valid (out_valid),
        .o_rgb   (o_rgb.rgb_color)
    );
endmodule

### rtl/hsvc_chk.sv
module hsvc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] out_data,
    input logic        pready
);
    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // input side follows the output stall
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");
endmodule

bind iteration_count_hsv_colorizer hsvc_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_pix.ready),
    .out_valid (o_rgb.valid),
    .out_ready (o_rgb.ready),
    .out_data  (o_rgb.rgb_color),
    .pready    (pready)
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import hsvc_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic [63:0] FX_ONE = 64'd1 << FRAC;
    localparam int LATENCY = 41;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic pready;

    hsvc_pix_if pix ();
    hsvc_rgb_if rgb ();

    iteration_count_hsv_colorizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .o_rgb   (rgb.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the register file
    t_cfg cfg;

    logic [23:0] rgb_expected[$];
    int mismatches;
    int sent_count;
    bit no_idle;
    bit hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] channel_of(logic [63:0] v, logic [63:0] x);
        return ((v * (FX_ONE - x) * 64'd255) >> FRAC) >> FRAC;
    endfunction

    function automatic logic [63:0] ramp_level(logic [63:0] count);
        if (count <= 2) return 0;
        if (count >= cfg.max_iterations) return FX_ONE;
        return ((count - 2) << FRAC) / (cfg.max_iterations - 2);
    endfunction

    function automatic logic [23:0] colorize(logic [15:0] iter);
        logic [63:0] count, hue, s, v, d, sector, f, vv, p, q, t, r, g, b;
        count = iter;
        hue = 0;
        s = FX_ONE;
        v = FX_ONE;
        if (count == cfg.max_iterations) return 24'h000000;
        if (cfg.color_mode == MODE_HUE) begin
            d = (cfg.hue_divisor == 0) ? 64'd1 : 64'(cfg.hue_divisor);
            hue = ((count * 360) / d) % 360;
        end else if (cfg.color_mode == MODE_SAT) begin
            hue = cfg.fixed_hue % 360;
            s = ramp_level(count);
        end else if (cfg.color_mode == MODE_VAL) begin
            hue = cfg.fixed_hue % 360;
            v = ramp_level(count);
        end
        sector = hue / 60;
        f = ((hue % 60) << FRAC) / 60;
        vv = (v * 255) >> FRAC;
        p = channel_of(v, s);
        q = channel_of(v, (s * f) >> FRAC);
        t = channel_of(v, (s * (FX_ONE - f)) >> FRAC);
        case (sector)
            0: begin r = vv; g = t; b = p; end
            1: begin r = q; g = vv; b = p; end
            2: begin r = p; g = vv; b = t; end
            3: begin r = p; g = q; b = vv; end
            4: begin r = t; g = p; b = vv; end
            default: begin r = vv; g = p; b = q; end
        endcase
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE: cfg.color_mode = value[1:0];
            REG_DIV:  cfg.hue_divisor = value[15:0];
            REG_HUE:  cfg.fixed_hue = value[8:0];
            default:  cfg.max_iterations = value[15:0];
        endcase
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        pix.valid <= 1'b0;
        while (rgb_expected.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // registers change only with the pipeline empty
    task automatic set_config(logic [1:0] mode, logic [15:0] div, logic [8:0] hue,
                              logic [15:0] max_it);
        drain();
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_DIV, 32'(div));
        write_reg(REG_HUE, 32'(hue));
        write_reg(REG_MAX, 32'(max_it));
    endtask

    // valid stays high after the request so back-to-back items leave no gap
    task automatic send_count(logic [15:0] iter);
        while (!no_idle && $urandom_range(99) < 31) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.iter_count <= iter;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        rgb_expected.push_back(colorize(iter));
        sent_count++;
    endtask

    // random count biased toward the limit and toward small counts
    function automatic logic [15:0] random_count();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(cfg.max_iterations + 2));
            2: return cfg.max_iterations;
            default: return 16'($urandom_range(8));
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'd50);
        send_count(16'd65535);
        drain();
    endtask

    task automatic test_directed;
        set_config(MODE_HUE, 16'd0, 9'd0, 16'd3);
        for (int i = 0; i < 7; i++) send_count(16'(i * 10 + 5));
        set_config(MODE_NONE, 16'd65535, 9'd511, 16'd65535);
        send_count(16'd7);
        send_count(16'd65535);
        send_count(16'd65534);
        set_config(MODE_SAT, 16'd1, 9'd359, 16'd2);
        send_count(16'd2);
        send_count(16'd3);
        send_count(16'd0);
        set_config(MODE_VAL, 16'd1, 9'd400, 16'd0);
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'd40000);
        set_config(MODE_VAL, 16'd1, 9'd200, 16'd65535);
        send_count(16'd3);
        send_count(16'd65534);
        send_count(16'hAAAA);
        send_count(16'h5555);
        drain();
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 12; ph++) begin
            set_config(2'($urandom_range(3)), 16'($urandom_range(65535)),
                       9'($urandom_range(511)),
                       (ph % 3 == 0) ? 16'($urandom_range(65535))
                                     : 16'($urandom_range(3, 120)));
            no_idle = (ph == 5);
            for (int i = 0; i < 70; i++) send_count(random_count());
            drain();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure;
        hold_off = 1'b1;
        for (int i = 0; i < 80; i++) send_count(random_count());
        pix.valid <= 1'b0;
        while (hold_off) @(posedge i_clk);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgb.ready <= 1'b0;
        end else begin
            rgb.ready <= !hold_off && (no_idle || $urandom_range(99) >= 31);
        end
    end

    // long receiver stall while the sender keeps pushing
    initial begin
        int cnt;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                cnt = 0;
                while (cnt < 300) begin
                    @(posedge i_clk);
                    cnt++;
                end
                hold_off = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n && rgb.valid && rgb.ready) begin
            if (rgb_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected rgb_color %06h", rgb.rgb_color);
            end else begin
                want = rgb_expected.pop_front();
                if (rgb.rgb_color !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("rgb_color mismatch: expected %06h got %06h",
                                 want, rgb.rgb_color);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        sent_count = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix.valid = 1'b0;
        pix.iter_count = '0;
        cfg.color_mode = MODE_HUE;
        cfg.hue_divisor = 16'd1;
        cfg.fixed_hue = 9'd0;
        cfg.max_iterations = 16'd50;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_random_phases();
        test_backpressure();
        if (mismatches == 0 && rgb_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
